// File: rtl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the addressed frame receiver
// Phase encoding, header layout, function and register codes, result record.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam int unsigned HEADER_BYTES = 5;
	localparam int unsigned COUNT_W      = 16;
	localparam int unsigned CFG_INDEX_W  = 8;

	// header positions, as byte counts within the header
	localparam logic [COUNT_W-1:0] HDR_POS_ADDR    = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] HDR_POS_FUNC    = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] HDR_POS_LEN_LO  = COUNT_W'(3);
	localparam logic [COUNT_W-1:0] HDR_POS_LAST    = COUNT_W'(HEADER_BYTES - 1);

	// functions that raise a host notification
	localparam logic [7:0] FUNC_NOTIFY_F1 = 8'hF1;
	localparam logic [7:0] FUNC_NOTIFY_F3 = 8'hF3;

	// notification codes: 0xB1 and 0xB3 on the host side
	localparam logic NOTIFY_CODE_B1 = 1'b0;
	localparam logic NOTIFY_CODE_B3 = 1'b1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESS = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = CFG_INDEX_W'(1);

	localparam logic [7:0] NODE_ADDRESS_RESET = 8'd0;
	localparam logic [7:0] START_MARKER_RESET = 8'h3A;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic               payload_valid;
		logic [COUNT_W-1:0] payload_index;
		logic [7:0]         payload_byte;
		logic               header_done;
		logic               address_match;
		logic               frame_done;
		logic               notify_valid;
		logic               notify_code;
		logic [7:0]         subfunction;
		logic [COUNT_W-1:0] frame_length;
	} afr_result_t;

endpackage

// File: rtl/afr_rx_if.sv
// ----------------------------------------------------------------------------
// afr_rx_if: received byte channel
// One bus byte per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface afr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/afr_cfg_if.sv
// ----------------------------------------------------------------------------
// afr_cfg_if: configuration write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface afr_cfg_if
	import afr_pkg::*;
	;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [7:0]             data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/afr_res_if.sv
// ----------------------------------------------------------------------------
// afr_res_if: per-byte result channel
// Payload, header and frame status for each received byte.
// ----------------------------------------------------------------------------
interface afr_res_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [15:0] payload_index;
	logic [7:0]  payload_byte;
	logic        header_done;
	logic        address_match;
	logic        frame_done;
	logic        notify_valid;
	logic        notify_code;
	logic [7:0]  subfunction;
	logic [15:0] frame_length;

	modport source (
		output valid, input ready,
		output payload_valid, output payload_index, output payload_byte,
		output header_done, output address_match, output frame_done,
		output notify_valid, output notify_code, output subfunction,
		output frame_length
	);
	modport sink (
		input valid, output ready,
		input payload_valid, input payload_index, input payload_byte,
		input header_done, input address_match, input frame_done,
		input notify_valid, input notify_code, input subfunction,
		input frame_length
	);
endinterface

// File: rtl/afr_parser.sv
// ----------------------------------------------------------------------------
// afr_parser: frame state machine
// Tracks idle/header/payload phase, captures the header, and builds the
// result record for each byte processed on step.
// ----------------------------------------------------------------------------
module afr_parser
	import afr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  node_address,
	input  logic [7:0]  start_marker,
	output afr_result_t result
);

	phase_t             phase_q, phase_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [7:0]         function_q, function_d;
	logic [COUNT_W-1:0] length_q, length_d;
	logic [7:0]         first_q, first_d;

	// header store: written before read within every header
	logic [7:0]         hdr_addr_q;
	logic [7:0]         hdr_func_q;
	logic [7:0]         hdr_len_lo_q;

	logic in_payload;
	logic hdr_last;
	logic hdr_match;

	assign in_payload = (count_q < length_q);
	assign hdr_last   = (count_q == HDR_POS_LAST);
	assign hdr_match  = (hdr_addr_q == node_address);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_PAYLOAD: begin
				if (!in_payload) begin
					phase_d = PH_IDLE;
				end
			end
			PH_HEADER: begin
				if (hdr_last) begin
					phase_d = hdr_match ? PH_PAYLOAD : PH_IDLE;
				end
			end
			default: begin
				if (rx_byte == start_marker) begin
					phase_d = PH_HEADER;
				end
			end
		endcase
	end

	// result record and data updates
	always_comb begin
		result     = '0;
		count_d    = count_q;
		function_d = function_q;
		length_d   = length_q;
		first_d    = first_q;
		case (phase_q)
			PH_PAYLOAD: begin
				if (in_payload) begin
					result.payload_valid = 1'b1;
					result.payload_index = count_q;
					result.payload_byte  = rx_byte;
					if (count_q == '0) begin
						first_d = rx_byte;
					end
					count_d = count_q + COUNT_W'(1);
				end else begin
					// closing byte: consumed, never a start marker
					result.frame_done   = 1'b1;
					result.subfunction  = first_q;
					result.frame_length = length_q;
					if (function_q == FUNC_NOTIFY_F1) begin
						result.notify_valid = 1'b1;
						result.notify_code  = NOTIFY_CODE_B1;
					end else if (function_q == FUNC_NOTIFY_F3) begin
						result.notify_valid = 1'b1;
						result.notify_code  = NOTIFY_CODE_B3;
					end
				end
			end
			PH_HEADER: begin
				if (hdr_last) begin
					result.header_done   = 1'b1;
					result.address_match = hdr_match;
					if (hdr_match) begin
						function_d = hdr_func_q;
						length_d   = {rx_byte, hdr_len_lo_q};
					end
					count_d = '0;
				end else begin
					count_d = count_q + COUNT_W'(1);
				end
			end
			default: begin
				// marker is the first header byte
				if (rx_byte == start_marker) begin
					count_d = COUNT_W'(1);
				end
			end
		endcase
	end

	// hold control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= '0;
			function_q <= '0;
			length_q   <= '0;
			first_q    <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			function_q <= function_d;
			length_q   <= length_d;
			first_q    <= first_d;
		end
	end

	// capture header bytes by position
	always_ff @(posedge clk) begin
		if (step && phase_q == PH_HEADER) begin
			if (count_q == HDR_POS_ADDR) begin
				hdr_addr_q <= rx_byte;
			end
			if (count_q == HDR_POS_FUNC) begin
				hdr_func_q <= rx_byte;
			end
			if (count_q == HDR_POS_LEN_LO) begin
				hdr_len_lo_q <= rx_byte;
			end
		end
	end

endmodule

// File: rtl/addressed_frame_receiver.sv
// ----------------------------------------------------------------------------
// addressed_frame_receiver: addressed bus frame receiver
// A byte is accepted into the input register and its result is loaded into
// the result register before it is presented; throughput is one byte per
// cycle while results are taken, set by the parser's phase update per step.
// Reset: phase idle, counters and frame fields cleared, node address 0,
// start marker 0x3A; configuration writes are always taken.
// ----------------------------------------------------------------------------
module addressed_frame_receiver
	import afr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	afr_rx_if.sink   rx,
	afr_cfg_if.sink  cfg,
	afr_res_if.source res
);

	logic        s1_valid_q;
	logic [7:0]  rx_byte_s1;
	logic        out_valid_q;
	afr_result_t res_q;
	afr_result_t result;
	logic [7:0]  node_address_q;
	logic [7:0]  start_marker_q;
	logic        step;

	// advance the byte in the input register when the result slot frees
	assign step     = s1_valid_q && (!out_valid_q || res.ready);
	assign rx.ready = !s1_valid_q || step;
	assign cfg.ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= NODE_ADDRESS_RESET;
			start_marker_q <= START_MARKER_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_NODE_ADDRESS: node_address_q <= cfg.data;
				REG_START_MARKER: start_marker_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (rx.ready) begin
			s1_valid_q <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	afr_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.rx_byte      (rx_byte_s1),
		.node_address (node_address_q),
		.start_marker (start_marker_q),
		.result       (result)
	);

	// result register: load on step, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= result;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.payload_valid = res_q.payload_valid;
	assign res.payload_index = res_q.payload_index;
	assign res.payload_byte  = res_q.payload_byte;
	assign res.header_done   = res_q.header_done;
	assign res.address_match = res_q.address_match;
	assign res.frame_done    = res_q.frame_done;
	assign res.notify_valid  = res_q.notify_valid;
	assign res.notify_code   = res_q.notify_code;
	assign res.subfunction   = res_q.subfunction;
	assign res.frame_length  = res_q.frame_length;

endmodule
